// File: hdl/nearest_color_code_lookup_top_defines.svh
// ----------------------------------------------------------------------------
// Nearest color code lookup: assertion macros
// Shared concurrent check forms, clocked on clk_i and held off during reset.
// ----------------------------------------------------------------------------
`ifndef NEAREST_COLOR_CODE_LOOKUP_TOP_DEFINES_SVH
`define NEAREST_COLOR_CODE_LOOKUP_TOP_DEFINES_SVH

// Same-cycle implication
`define NCLUT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define NCLUT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/nclut_pkg.sv
// ----------------------------------------------------------------------------
// Nearest color code lookup: package
// Table size, derived widths, word layouts and controller/datapath links.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package nclut_pkg;

  // Table geometry
  localparam int TABLE_ENTRIES = 32;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

  // Fixed field widths
  localparam int CFG_W   = 6;
  localparam int SLOT_W  = 5;
  localparam int COLOR_W = 8;
  localparam int CODE_W  = 16;
  localparam int SQ_W    = 2 * COLOR_W;
  localparam int DIST_W  = 18;

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 40;

  // Reset value of the entries-in-use register
  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(18);

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic {
    ACT_LOAD  = 1'b0,
    ACT_QUERY = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_EMIT
  } state_e;

  // Input word, last field in the lowest bits
  typedef struct packed {
    logic [2:0]         pad;
    logic [CODE_W-1:0]  entry_code;
    logic [COLOR_W-1:0] blue;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] red;
    logic [SLOT_W-1:0]  entry_index;
  } in_word_t;

  // Output word, last field in the lowest bits
  typedef struct packed {
    logic               pad;
    logic [DIST_W-1:0]  match_distance;
    logic [SLOT_W-1:0]  match_index;
    logic [CODE_W-1:0]  match_code;
  } out_word_t;

  // One table entry
  typedef struct packed {
    logic [CODE_W-1:0]  code;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } entry_t;

  // Controller to datapath
  typedef struct packed {
    logic load_we;
    idx_t load_addr;
    logic query_start;
    logic issue;
    logic issue_first;
    logic issue_last;
    idx_t issue_addr;
    logic emit;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_done;
    logic out_free;
  } dp_status_t;

  // Squared difference of two color components
  function automatic logic [SQ_W-1:0] sq_diff(input logic [COLOR_W-1:0] a,
                                               input logic [COLOR_W-1:0] b);
    logic [COLOR_W-1:0] d;
    d = (a >= b) ? (a - b) : (b - a);
    return SQ_W'(d) * SQ_W'(d);
  endfunction

endpackage

// File: hdl/nearest_color_code_lookup_top.sv
// ----------------------------------------------------------------------------
// Nearest color code lookup: a load writes the table, next word taken next cycle.
// Query: reads entries 0 to N-1, one per cycle, N = clamped entries in use,
// through read register, distance stage and running best to the output register;
// no new word until the result is emitted, which an unread result word holds off.
// Reset clears control, sets entries in use to 18; table undefined until loaded.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "nearest_color_code_lookup_top_defines.svh"

module nearest_color_code_lookup_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration: entries in use
  input  logic                                cfg_we_i,
  input  logic [nclut_pkg::CFG_W-1:0]         cfg_wdata_i,
  // Input words
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // entry_index[4:0], red[12:5], green[20:13], blue[28:21], entry_code[44:29]
  input  logic [nclut_pkg::IN_DATA_W-1:0]     s_axis_tdata_i,
  // action[0]
  input  logic                                s_axis_tuser_i,
  // Result words
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // match_code[15:0], match_index[20:16], match_distance[38:21]
  output logic [nclut_pkg::OUT_DATA_W-1:0]    m_axis_tdata_o
);

  nclut_pkg::in_word_t    in_word;
  nclut_pkg::out_word_t   out_word;
  nclut_pkg::ctrl_cmd_t   cmd;
  nclut_pkg::dp_status_t  status;

  assign in_word        = nclut_pkg::in_word_t'(s_axis_tdata_i);
  assign m_axis_tdata_o = nclut_pkg::OUT_DATA_W'(out_word);

  nclut_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_action_i (s_axis_tuser_i),
    .in_slot_i   (in_word.entry_index),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  nclut_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word_i   (in_word),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_word_o  (out_word)
  );

  // Checks
  `NCLUT_ASSERT_NEXT(a_query_starts_scan,
    s_axis_tvalid_i && s_axis_tready_o && (s_axis_tuser_i == nclut_pkg::ACT_QUERY),
    cmd.issue && cmd.issue_first, "query accepted but scan did not start at entry 0")
  `NCLUT_ASSERT_NOW(a_no_input_during_scan, cmd.issue || status.scan_done,
    !s_axis_tready_o, "input taken while a scan is in progress")
  `NCLUT_ASSERT_NOW(a_emit_needs_room, cmd.emit,
    !m_axis_tvalid_o || m_axis_tready_i, "result overwrote a word still waiting")
  `NCLUT_ASSERT_NOW(a_load_not_in_scan, cmd.load_we,
    !cmd.issue && !cmd.emit, "table write during scan or emit")

endmodule

// File: hdl/nclut_ctrl.sv
// ----------------------------------------------------------------------------
// Nearest color code lookup: controller
// Takes input words, holds the entries-in-use register and sequences the scan.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nclut_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [nclut_pkg::CFG_W-1:0]   cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          in_action_i,
  input  logic [nclut_pkg::SLOT_W-1:0]  in_slot_i,
  input  nclut_pkg::dp_status_t         status_i,
  output nclut_pkg::ctrl_cmd_t          cmd_o
);

  nclut_pkg::state_e                state_q, state_d;
  logic [nclut_pkg::CFG_W-1:0]      cfg_q;
  nclut_pkg::cnt_t                  count_q, count_d;
  nclut_pkg::idx_t                  idx_q, idx_d;
  nclut_pkg::cnt_t                  count_sat;
  logic                             last_issue;

  // Clamp entries-in-use to 1 .. TABLE_ENTRIES
  assign count_sat = (cfg_q == '0) ? nclut_pkg::cnt_t'(1) :
                     (32'(cfg_q) > 32'(nclut_pkg::TABLE_ENTRIES)) ?
                       nclut_pkg::cnt_t'(nclut_pkg::TABLE_ENTRIES) :
                       nclut_pkg::cnt_t'(cfg_q);

  assign last_issue = ((32'(idx_q) + 32'd1) == 32'(count_q));

  // Hold the configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= nclut_pkg::CFG_RESET;
    end else if (cfg_we_i) begin
      cfg_q <= cfg_wdata_i;
    end
  end

  // State, scan counter and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= nclut_pkg::ST_IDLE;
      count_q <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      idx_q   <= idx_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    cmd_o.load_addr  = nclut_pkg::idx_t'(in_slot_i);
    cmd_o.issue_addr = idx_q;
    case (state_q)
      nclut_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_action_i == nclut_pkg::ACT_QUERY) begin
            cmd_o.query_start = 1'b1;
            count_d = count_sat;
            idx_d   = '0;
            state_d = nclut_pkg::ST_SCAN;
          end else begin
            // Drop loads to slots beyond the table
            cmd_o.load_we = (32'(in_slot_i) < 32'(nclut_pkg::TABLE_ENTRIES));
          end
        end
      end
      nclut_pkg::ST_SCAN: begin
        cmd_o.issue       = 1'b1;
        cmd_o.issue_first = (idx_q == '0);
        cmd_o.issue_last  = last_issue;
        if (last_issue) begin
          state_d = nclut_pkg::ST_DRAIN;
        end else begin
          idx_d = idx_q + nclut_pkg::idx_t'(1);
        end
      end
      nclut_pkg::ST_DRAIN: begin
        if (status_i.scan_done) begin
          state_d = nclut_pkg::ST_EMIT;
        end
      end
      nclut_pkg::ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = nclut_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = nclut_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: hdl/nclut_datapath.sv
// ----------------------------------------------------------------------------
// Nearest color code lookup: datapath
// Table memory, distance pipeline, running minimum and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nclut_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  nclut_pkg::in_word_t              in_word_i,
  input  nclut_pkg::ctrl_cmd_t             cmd_i,
  output nclut_pkg::dp_status_t            status_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output nclut_pkg::out_word_t             out_word_o
);

  nclut_pkg::entry_t                       mem [nclut_pkg::TABLE_ENTRIES];
  nclut_pkg::entry_t                       rd_q;
  logic [nclut_pkg::COLOR_W-1:0]           q_red_q, q_green_q, q_blue_q;

  // Stage 1: read data
  logic                                    s1_valid_q, s1_first_q, s1_last_q;
  nclut_pkg::idx_t                         s1_idx_q;

  // Stage 2: distance
  logic                                    s2_valid_q, s2_first_q, s2_last_q;
  nclut_pkg::idx_t                         s2_idx_q;
  logic [nclut_pkg::CODE_W-1:0]            s2_code_q;
  logic [nclut_pkg::DIST_W-1:0]            s2_dist_q, dist_d;

  // Running best
  nclut_pkg::idx_t                         best_idx_q;
  logic [nclut_pkg::CODE_W-1:0]            best_code_q;
  logic [nclut_pkg::DIST_W-1:0]            best_dist_q;
  logic                                    take_best;

  logic                                    out_valid_q;
  nclut_pkg::out_word_t                    out_word_q;

  // Table write on load, registered read on scan issue
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_we) begin
      mem[cmd_i.load_addr] <= '{code:  in_word_i.entry_code,
                                red:   in_word_i.red,
                                green: in_word_i.green,
                                blue:  in_word_i.blue};
    end
    if (cmd_i.issue) begin
      rd_q <= mem[cmd_i.issue_addr];
    end
  end

  // Latch the query color
  always_ff @(posedge clk_i) begin
    if (cmd_i.query_start) begin
      q_red_q   <= in_word_i.red;
      q_green_q <= in_word_i.green;
      q_blue_q  <= in_word_i.blue;
    end
  end

  // Sum of squared component differences
  assign dist_d = nclut_pkg::DIST_W'(nclut_pkg::sq_diff(q_red_q, rd_q.red))
                + nclut_pkg::DIST_W'(nclut_pkg::sq_diff(q_green_q, rd_q.green))
                + nclut_pkg::DIST_W'(nclut_pkg::sq_diff(q_blue_q, rd_q.blue));

  // Pipeline control flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_first_q <= 1'b0;
      s1_last_q  <= 1'b0;
      s2_valid_q <= 1'b0;
      s2_first_q <= 1'b0;
      s2_last_q  <= 1'b0;
    end else begin
      s1_valid_q <= cmd_i.issue;
      s1_first_q <= cmd_i.issue_first;
      s1_last_q  <= cmd_i.issue_last;
      s2_valid_q <= s1_valid_q;
      s2_first_q <= s1_first_q;
      s2_last_q  <= s1_last_q;
    end
  end

  // Pipeline payload
  always_ff @(posedge clk_i) begin
    s1_idx_q  <= cmd_i.issue_addr;
    s2_idx_q  <= s1_idx_q;
    s2_code_q <= rd_q.code;
    s2_dist_q <= dist_d;
  end

  // Take the first entry, then replace the best only on a strictly smaller distance; lowest index wins ties
  assign take_best = s2_valid_q && (s2_first_q || (s2_dist_q < best_dist_q));

  always_ff @(posedge clk_i) begin
    if (take_best) begin
      best_idx_q  <= s2_idx_q;
      best_code_q <= s2_code_q;
      best_dist_q <= s2_dist_q;
    end
  end

  assign status_o.scan_done = s2_valid_q && s2_last_q;
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_word_q.pad            <= 1'b0;
      out_word_q.match_distance <= best_dist_q;
      out_word_q.match_index    <= nclut_pkg::SLOT_W'(best_idx_q);
      out_word_q.match_code     <= best_code_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule
